@@ hw/rtl/swr_pkg.sv @@
// Shared types and constants for the stop-and-wait receiver with Adler-32 check.
// Holds packet type codes, event codes, fixed handshake checksums and queue sizing.
// No dependencies.
`timescale 1ns / 1ps

package swr_pkg;

  // Packet type codes as carried in the header and in replies.
  localparam logic [2:0] T_DATA      = 3'd0;
  localparam logic [2:0] T_LAST_DATA = 3'd1;
  localparam logic [2:0] T_ACK       = 3'd2;
  localparam logic [2:0] T_SYN       = 3'd3;
  localparam logic [2:0] T_SYNACK    = 3'd4;
  localparam logic [2:0] T_TERM      = 3'd5;
  localparam logic [2:0] T_ACKCON    = 3'd6;
  localparam logic [2:0] T_KEEPALIVE = 3'd7;

  // Connection event codes.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_CONNECT = 2'd1;
  localparam logic [1:0] EV_TERM    = 2'd2;

  // Adler-32 modulus.
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Adler-32 of the fixed handshake words "synch", "term" and "ackcon".
  localparam logic [31:0] ADLER_SYN    = 32'h06A0_0226;
  localparam logic [31:0] ADLER_TERM   = 32'h0454_01B9;
  localparam logic [31:0] ADLER_ACKCON = 32'h085C_0270;

  // Defaults for the top-level parameters.
  localparam int MAX_PAYLOAD_BYTES_DEF = 1024;
  localparam int SEQ_MODULUS_DEF       = 16;

  // Queue between the front and the back part.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One finished packet as seen by the decision logic.
  typedef struct packed {
    logic       verified;
    logic [2:0] pkt_type;
    logic [3:0] pkt_seq;
    logic       syn_ok;
    logic       term_ok;
    logic       ackcon_ok;
  } summary_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ hw/rtl/swr_front.sv @@
// Front part: accepts payload bytes, keeps the running Adler-32 sum and byte count,
// and pushes one packet summary when a packet ends. Depends on swr_pkg.
`timescale 1ns / 1ps

module swr_front import swr_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  payload_byte,
  input  logic        last_byte,
  input  logic        empty_payload,
  input  logic [2:0]  pkt_type,
  input  logic [3:0]  pkt_seq,
  input  logic [31:0] pkt_checksum,
  output logic        push,
  output summary_t    summary
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD_BYTES);

  logic [15:0]      sum_low;
  logic [15:0]      sum_high;
  logic [CNT_W-1:0] byte_count;
  logic             overlong;

  logic [16:0]      a_raw;
  logic [15:0]      a_mod;
  logic [16:0]      b_raw;
  logic [15:0]      b_mod;
  logic             overlong_next;
  logic [CNT_W-1:0] byte_count_next;
  logic             pkt_end;

  // Two chained modular adds per byte.
  always_comb begin
    a_raw = {1'b0, sum_low} + {9'd0, payload_byte};
    a_mod = (a_raw >= ADLER_MOD) ? 16'(a_raw - ADLER_MOD) : a_raw[15:0];
    b_raw = {1'b0, sum_high} + {1'b0, a_mod};
    b_mod = (b_raw >= ADLER_MOD) ? 16'(b_raw - ADLER_MOD) : b_raw[15:0];
  end

  // Count saturates at the payload limit; a byte past it flags the packet overlong.
  always_comb begin
    overlong_next   = overlong;
    byte_count_next = byte_count;
    if (byte_count >= CNT_MAX) begin
      overlong_next = 1'b1;
    end else begin
      byte_count_next = byte_count + 1'b1;
    end
  end

  // An empty-payload item ends the packet whatever last_byte says.
  assign pkt_end = accept && (empty_payload || last_byte);
  assign push    = pkt_end;

  // Summary of the packet that ends with this item.
  always_comb begin
    summary.verified  = !empty_payload && !overlong_next &&
                        ({b_mod, a_mod} == pkt_checksum);
    summary.pkt_type  = pkt_type;
    summary.pkt_seq   = pkt_seq;
    summary.syn_ok    = (pkt_checksum == ADLER_SYN);
    summary.term_ok   = (pkt_checksum == ADLER_TERM);
    summary.ackcon_ok = (pkt_checksum == ADLER_ACKCON);
  end

  // Accumulators return to their start values after each packet.
  always_ff @(posedge clk) begin
    if (rst || pkt_end) begin
      sum_low    <= 16'd1;
      sum_high   <= 16'd0;
      byte_count <= '0;
      overlong   <= 1'b0;
    end else if (accept) begin
      sum_low    <= a_mod;
      sum_high   <= b_mod;
      byte_count <= byte_count_next;
      overlong   <= overlong_next;
    end
  end

endmodule

@@ hw/rtl/swr_queue.sv @@
// Short queue of packet summaries between the front and the back part.
// Depends on swr_pkg for the summary type and the depth.
`timescale 1ns / 1ps

module swr_queue import swr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  summary_t      push_data,
  input  logic          pop,
  output summary_t      head,
  output queue_status_t status
);

  summary_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Storage is written only; entries need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap with the power-of-two depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/swr_back.sv @@
// Back part: takes packet summaries, keeps the expected sequence number and
// registers one reply decision per packet. Depends on swr_pkg.
`timescale 1ns / 1ps

module swr_back import swr_pkg::*; #(
  parameter int SEQ_MODULUS = SEQ_MODULUS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  summary_t   head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] reply_type,
  output logic [3:0] reply_seq,
  output logic       deliver,
  output logic       message_end,
  output logic [1:0] connection_event
);

  localparam int SEQ_W = (SEQ_MODULUS > 2) ? $clog2(SEQ_MODULUS) : 1;
  localparam int CMP_W = (SEQ_W > 4) ? SEQ_W : 4;
  localparam logic [SEQ_W-1:0] SEQ_TOP = SEQ_W'(SEQ_MODULUS - 1);

  logic [SEQ_W-1:0] expected_seq;
  logic [SEQ_W-1:0] expected_seq_next;
  logic [SEQ_W-1:0] prev_seq;
  logic [CMP_W-1:0] seq_ext;
  logic [CMP_W-1:0] exp_ext;
  logic [CMP_W-1:0] prev_ext;
  logic             in_order;
  logic             duplicate;

  logic [2:0]       rtype;
  logic [3:0]       rseq;
  logic             dlv;
  logic             mend;
  logic [1:0]       ev;

  assign pop = head_valid && (!out_valid || out_ready);

  // Sequence compares at a common width; header values past the modulus never match.
  always_comb begin
    prev_seq  = (expected_seq == '0) ? SEQ_TOP : expected_seq - 1'b1;
    seq_ext   = CMP_W'(head.pkt_seq);
    exp_ext   = CMP_W'(expected_seq);
    prev_ext  = CMP_W'(prev_seq);
    in_order  = head.verified && (seq_ext == exp_ext) &&
                (head.pkt_type != T_ACK) && (head.pkt_type != T_ACKCON);
    duplicate = head.verified && (seq_ext == prev_ext);
  end

  // Reply decision, in priority order.
  always_comb begin
    rtype             = T_KEEPALIVE;
    rseq              = 4'd0;
    dlv               = 1'b0;
    mend              = 1'b0;
    ev                = EV_NONE;
    expected_seq_next = expected_seq;
    if (head.pkt_type == T_SYN && head.syn_ok) begin
      rtype = T_SYN;
      ev    = EV_CONNECT;
    end else if (head.pkt_type == T_TERM && head.term_ok) begin
      rtype = T_TERM;
      ev    = EV_TERM;
    end else if (in_order) begin
      rtype             = T_ACK;
      rseq              = exp_ext[3:0];
      dlv               = 1'b1;
      mend              = (head.pkt_type == T_LAST_DATA);
      expected_seq_next = (expected_seq == SEQ_TOP) ? '0 : expected_seq + 1'b1;
    end else if (duplicate) begin
      rtype = T_ACK;
      rseq  = head.pkt_seq;
    end else if (head.pkt_type == T_ACKCON && head.ackcon_ok) begin
      rtype = T_ACKCON;
    end
  end

  // Sequence state advances only when a decision is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0;
    end else if (pop) begin
      expected_seq <= expected_seq_next;
    end
  end

  // Output register: refilled whenever it is empty or being drained and a summary is waiting.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      reply_type       <= rtype;
      reply_seq        <= rseq;
      deliver          <= dlv;
      message_end      <= mend;
      connection_event <= ev;
    end
  end

endmodule

@@ hw/rtl/stop_and_wait_receiver_adler32.sv @@
// Stop-and-wait receiver with Adler-32 check: one payload byte item per cycle.
// Once its last byte is taken, a packet's summary is registered in the queue, then its reply in the output register.
// Throughput: one byte item per cycle; input stalls only when the four-entry summary
// queue is full, which happens only if the reply output is held back.
// Reset: synchronous, active high; clears sums, counts, expected sequence, queue and
// output valid at once.
`timescale 1ns / 1ps

module stop_and_wait_receiver_adler32 import swr_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  parameter int SEQ_MODULUS       = SEQ_MODULUS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // payload_byte[7:0], pkt_seq[11:8], pkt_checksum[43:12], zero
  input  logic        s_axis_tlast,  // last_byte
  input  logic [3:0]  s_axis_tuser,  // empty_payload[0], pkt_type[3:1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // reply_seq[3:0], deliver[4], message_end[5],
                                     // connection_event[7:6]
  output logic [2:0]  m_axis_tuser   // reply_type[2:0]
);

  logic          accept;
  logic          q_push;
  summary_t      q_in;
  summary_t      q_head;
  logic          q_pop;
  queue_status_t q_status;

  logic [3:0]    reply_seq;
  logic          deliver;
  logic          message_end;
  logic [1:0]    connection_event;

  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Front: checksum accumulation and packet classification.
  swr_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (s_axis_tdata[7:0]),
    .last_byte    (s_axis_tlast),
    .empty_payload(s_axis_tuser[0]),
    .pkt_type     (s_axis_tuser[3:1]),
    .pkt_seq      (s_axis_tdata[11:8]),
    .pkt_checksum (s_axis_tdata[43:12]),
    .push         (q_push),
    .summary      (q_in)
  );

  // Queue of finished packets.
  swr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  // Back: sequence tracking and reply decision.
  swr_back #(
    .SEQ_MODULUS(SEQ_MODULUS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (!q_status.empty),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .reply_type      (m_axis_tuser),
    .reply_seq       (reply_seq),
    .deliver         (deliver),
    .message_end     (message_end),
    .connection_event(connection_event)
  );

  assign m_axis_tdata = {connection_event, message_end, deliver, reply_seq};

  // A packet-ending item always leaves a summary waiting in the queue.
  a_end_queued: assert property (@(posedge clk) disable iff (rst)
    (accept && (s_axis_tlast || s_axis_tuser[0])) |=> !q_status.empty)
    else $error("packet end was not queued");

  // Input stalls exactly when the queue cannot take another summary.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_status.full)
    else $error("input stalled without a full queue");

  // A delivered packet is always acknowledged and raises no connection event.
  a_deliver_ack: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[4]) |->
      (m_axis_tuser == T_ACK && m_axis_tdata[7:6] == EV_NONE))
    else $error("delivery without a plain acknowledge");

  // Message end is only flagged on a delivered packet.
  a_mend_deliver: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tdata[4])
    else $error("message end without delivery");

endmodule

@@ dv/stop_and_wait_receiver_adler32_tb.sv @@
// Self-checking testbench for the stop-and-wait receiver with Adler-32 check.
// Drives packet byte streams with random idling and stalls, and predicts every reply.
// Depends on swr_pkg and stop_and_wait_receiver_adler32.
`timescale 1ns / 1ps

module stop_and_wait_receiver_adler32_tb;
  import swr_pkg::*;

  // One input item: a payload byte with the packet header alongside.
  typedef struct {
    bit [7:0]  data;
    bit        last;
    bit        empty;
    bit [2:0]  ptype;
    bit [3:0]  seq;
    bit [31:0] csum;
  } rx_item_t;

  // One reply decision.
  typedef struct {
    bit [2:0] rtype;
    bit [3:0] rseq;
    bit       deliver;
    bit       msg_end;
    bit [1:0] conn_ev;
  } reply_t;

  // Sender and receiver idling modes.
  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // Tracks the receiver state and the replies still owed by the block.
  class reply_scoreboard_t;
    bit [16:0] sum_a;
    bit [16:0] sum_b;
    int        nbytes;
    bit        overlong;
    bit [3:0]  next_seq;
    reply_t    replies_q[$];
    int        errors;

    function new();
      clear_packet();
      next_seq = 4'd0;
      errors = 0;
    endfunction

    function void clear_packet();
      sum_a = 17'd1;
      sum_b = 17'd0;
      nbytes = 0;
      overlong = 1'b0;
    endfunction

    function int pending();
      return replies_q.size();
    endfunction

    // Updates the running sum and, at the end of a packet, queues the decision.
    function void note_input(rx_item_t it);
      bit       verified;
      bit [3:0] prev_seq;
      reply_t   r;
      if (!it.empty) begin
        // The byte count saturates; one byte past the limit marks the packet corrupt.
        if (nbytes >= MAX_PAYLOAD_BYTES_DEF) overlong = 1'b1;
        else nbytes++;
        sum_a = sum_a + it.data;
        if (sum_a >= ADLER_MOD) sum_a = sum_a - ADLER_MOD;
        sum_b = sum_b + sum_a;
        if (sum_b >= ADLER_MOD) sum_b = sum_b - ADLER_MOD;
        if (!it.last) return;
      end
      verified = !it.empty && !overlong && nbytes > 0 &&
                 ({sum_b[15:0], sum_a[15:0]} == it.csum);
      // Sequence numbers wrap at 16, the width of the field.
      prev_seq = next_seq - 4'd1;
      r = '{T_KEEPALIVE, 4'd0, 1'b0, 1'b0, EV_NONE};
      if (it.ptype == T_SYN && it.csum == ADLER_SYN) begin
        r.rtype = T_SYN;
        r.conn_ev = EV_CONNECT;
      end else if (it.ptype == T_TERM && it.csum == ADLER_TERM) begin
        r.rtype = T_TERM;
        r.conn_ev = EV_TERM;
      end else if (verified && it.seq == next_seq && it.ptype != T_ACK &&
                   it.ptype != T_ACKCON) begin
        r.rtype = T_ACK;
        r.rseq = next_seq;
        r.deliver = 1'b1;
        r.msg_end = (it.ptype == T_LAST_DATA);
        next_seq = next_seq + 4'd1;
      end else if (verified && it.seq == prev_seq) begin
        r.rtype = T_ACK;
        r.rseq = it.seq;
      end else if (it.ptype == T_ACKCON && it.csum == ADLER_ACKCON) begin
        r.rtype = T_ACKCON;
      end
      clear_packet();
      replies_q.push_back(r);
    endfunction

    // Compares one accepted reply with the oldest one owed.
    function void check_result(reply_t got);
      reply_t want;
      if (replies_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected reply: type %0d seq %0d deliver %0d end %0d event %0d",
                   got.rtype, got.rseq, got.deliver, got.msg_end, got.conn_ev);
        return;
      end
      want = replies_q.pop_front();
      if (want.rtype != got.rtype || want.rseq != got.rseq || want.deliver != got.deliver ||
          want.msg_end != got.msg_end || want.conn_ev != got.conn_ev) begin
        errors++;
        if (errors <= 10)
          $display("Reply mismatch: expected type %0d seq %0d deliver %0d end %0d event %0d, %s",
                   want.rtype, want.rseq, want.deliver, want.msg_end, want.conn_ev,
                   $sformatf("got type %0d seq %0d deliver %0d end %0d event %0d",
                             got.rtype, got.rseq, got.deliver, got.msg_end, got.conn_ev));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  reply_scoreboard_t sb = new();
  idle_mode_t      mode = IDLE_NONE;
  int              hold_req = 0;
  int              hold_left = 0;
  int              item_count = 0;
  bit [7:0]        payload_q[$];
  reply_t          seen_reply;
  bit [2:0]        data_types[6] = '{T_DATA, T_LAST_DATA, T_SYN, T_SYNACK, T_TERM, T_KEEPALIVE};

  stop_and_wait_receiver_adler32 u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Reply side: check accepted replies, then choose the next ready level.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_reply.rtype = m_axis_tuser;
      seen_reply.rseq = m_axis_tdata[3:0];
      seen_reply.deliver = m_axis_tdata[4];
      seen_reply.msg_end = m_axis_tdata[5];
      seen_reply.conn_ev = m_axis_tdata[7:6];
      sb.check_result(seen_reply);
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (mode == IDLE_RECV) begin
      m_axis_tready <= ($urandom_range(99) >= 70);
    end else if (mode == IDLE_BOTH) begin
      m_axis_tready <= ($urandom_range(99) >= 34);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Adler-32 of the bytes now in the payload buffer.
  function automatic bit [31:0] payload_adler();
    bit [16:0] a;
    bit [16:0] b;
    a = 17'd1;
    b = 17'd0;
    foreach (payload_q[i]) begin
      a = a + payload_q[i];
      if (a >= ADLER_MOD) a = a - ADLER_MOD;
      b = b + a;
      if (b >= ADLER_MOD) b = b - ADLER_MOD;
    end
    return {b[15:0], a[15:0]};
  endfunction

  function automatic void fill_payload(int len);
    payload_q.delete();
    repeat (len) payload_q.push_back(8'($urandom_range(255)));
  endfunction

  // Offers one item after an optional idle gap and waits until it is taken.
  task automatic send_item(rx_item_t it);
    int gap;
    gap = 0;
    if (mode == IDLE_SEND) begin
      while ($urandom_range(99) < 70) gap++;
    end else if (mode == IDLE_BOTH) begin
      while ($urandom_range(99) < 34) gap++;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.csum, it.seq, it.data};
    s_axis_tlast <= it.last;
    s_axis_tuser <= {it.ptype, it.empty};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(it);
    item_count++;
  endtask

  // Sends the payload buffer as one packet, optionally closed by an empty-payload item.
  task automatic send_packet(bit [2:0] ptype, bit [3:0] seq, bit [31:0] csum,
                             bit end_empty);
    rx_item_t it;
    for (int i = 0; i < payload_q.size(); i++) begin
      it.data = payload_q[i];
      it.last = !end_empty && (i == payload_q.size() - 1);
      it.empty = 1'b0;
      it.ptype = ptype;
      it.seq = seq;
      it.csum = csum;
      // Header fields on earlier bytes are ignored, so scramble them now and then.
      if (!it.last && $urandom_range(3) == 0) begin
        it.ptype = 3'($urandom_range(7));
        it.seq = 4'($urandom_range(15));
        it.csum = $urandom;
      end
      send_item(it);
    end
    if (end_empty) begin
      it.data = 8'($urandom_range(255));
      it.last = 1'($urandom_range(1));
      it.empty = 1'b1;
      it.ptype = ptype;
      it.seq = seq;
      it.csum = csum;
      send_item(it);
    end
  endtask

  // Stops offering and waits for every owed reply before returning.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One random packet, mostly well formed with the right sequence number.
  task automatic random_packet();
    int        pick;
    int        len;
    bit [2:0]  ptype;
    bit [3:0]  seq;
    bit [31:0] sum;
    pick = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    fill_payload(len);
    sum = payload_adler();
    ptype = data_types[3'($urandom_range(5))];
    seq = sb.next_seq;
    if (pick < 40) begin
      // In-order packet with a good checksum.
    end else if (pick < 50) begin
      seq = sb.next_seq - 4'd1;
    end else if (pick < 58) begin
      ptype = T_ACK;
      if ($urandom_range(1)) seq = sb.next_seq - 4'd1;
    end else if (pick < 66) begin
      sum = sum ^ (($urandom_range(1) == 1) ? (32'd1 << $urandom_range(31)) : ($urandom | 32'd1));
    end else if (pick < 72) begin
      seq = sb.next_seq + 4'($urandom_range(1, 14));
    end else if (pick < 77) begin
      ptype = T_SYN;
      sum = ADLER_SYN;
      seq = 4'($urandom_range(15));
    end else if (pick < 82) begin
      ptype = T_TERM;
      sum = ADLER_TERM;
      seq = 4'($urandom_range(15));
    end else if (pick < 87) begin
      ptype = T_ACKCON;
      sum = ADLER_ACKCON;
      seq = 4'($urandom_range(15));
    end else if (pick < 93) begin
      // Packet cut short by an empty-payload item.
      fill_payload($urandom_range(0, 3));
      ptype = 3'($urandom_range(7));
      seq = 4'($urandom_range(15));
      case ($urandom_range(4))
        0: sum = 32'd1;
        1: begin ptype = T_SYN; sum = ADLER_SYN; end
        2: begin ptype = T_TERM; sum = ADLER_TERM; end
        3: begin ptype = T_ACKCON; sum = ADLER_ACKCON; end
        default: sum = $urandom;
      endcase
      send_packet(ptype, seq, sum, 1'b1);
      return;
    end else begin
      ptype = 3'($urandom_range(7));
      seq = 4'($urandom_range(15));
      sum = $urandom;
    end
    send_packet(ptype, seq, sum, 1'b0);
  endtask

  // Run limit.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int start_count;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Handshake packets with their fixed checksums, with and without payload.
    payload_q = '{8'h78};
    send_packet(T_SYN, 4'd0, ADLER_SYN, 1'b0);
    payload_q.delete();
    send_packet(T_SYN, 4'd0, ADLER_SYN, 1'b1);
    fill_payload(2);
    send_packet(T_TERM, 4'd9, ADLER_TERM, 1'b0);
    fill_payload(1);
    send_packet(T_ACKCON, 4'd3, ADLER_ACKCON, 1'b0);

    // In-order data, message end, duplicate and acknowledgement packets.
    payload_q = '{8'h00, 8'hFF};
    send_packet(T_DATA, sb.next_seq, payload_adler(), 1'b0);
    payload_q = '{8'hFF};
    send_packet(T_LAST_DATA, sb.next_seq, payload_adler(), 1'b0);
    fill_payload(3);
    send_packet(T_DATA, sb.next_seq - 4'd1, payload_adler(), 1'b0);
    fill_payload(2);
    send_packet(T_ACK, sb.next_seq, payload_adler(), 1'b0);
    fill_payload(1);
    send_packet(T_ACK, sb.next_seq - 4'd1, payload_adler(), 1'b0);

    // Corrupt payloads: empty, bad checksum, bytes dropped by an empty item.
    payload_q.delete();
    send_packet(T_DATA, sb.next_seq, 32'd1, 1'b1);
    fill_payload(2);
    send_packet(T_DATA, sb.next_seq, ~payload_adler(), 1'b0);
    fill_payload(3);
    send_packet(T_DATA, sb.next_seq, payload_adler(), 1'b1);

    // A verified connection acknowledgement is never delivered; SYNACK and the other type are.
    fill_payload(2);
    send_packet(T_ACKCON, sb.next_seq, payload_adler(), 1'b0);
    fill_payload(1);
    send_packet(T_SYNACK, sb.next_seq, payload_adler(), 1'b0);
    fill_payload(1);
    send_packet(T_KEEPALIVE, sb.next_seq, payload_adler(), 1'b0);

    // Largest allowed payload, then one byte too many.
    payload_q.delete();
    repeat (MAX_PAYLOAD_BYTES_DEF) payload_q.push_back(8'hFF);
    send_packet(T_DATA, sb.next_seq, payload_adler(), 1'b0);
    payload_q.push_back(8'hFF);
    send_packet(T_DATA, sb.next_seq, payload_adler(), 1'b0);
    drain();

    // Random packets under each idling mode; the first mode also holds replies back.
    for (int m = 0; m < 4; m++) begin
      mode = idle_mode_t'(m);
      if (mode == IDLE_NONE) hold_req = 80;
      start_count = item_count;
      while (item_count - start_count < 125) random_packet();
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
